// ===== rtl/fcce_pkg.sv =====
// Shared constants, codes and types for the cluster chain engine.
package fcce_pkg;

  localparam int TABLE_DEPTH = 4096;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = ADDR_W + 1;

  localparam logic [31:0] FIRST_CLUSTER = 32'd2;
  localparam logic [31:0] END_MARK      = 32'h0FFF_FFFF;
  localparam logic [31:0] END_THRESHOLD = 32'h0FFF_FFF8;
  localparam logic [ADDR_W-1:0] MAX_COUNT = ADDR_W'(TABLE_DEPTH - 2);

  // Request codes
  localparam logic [2:0] REQ_ALLOC = 3'd0;
  localparam logic [2:0] REQ_FREE  = 3'd1;
  localparam logic [2:0] REQ_MAP   = 3'd2;
  localparam logic [2:0] REQ_READ  = 3'd3;
  localparam logic [2:0] REQ_WRITE = 3'd4;

  // Status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_BROKEN = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_COUNT = 2'd0;
  localparam logic [1:0] CFG_SPC   = 2'd1;
  localparam logic [1:0] CFG_FDS   = 2'd2;

  // Request to the shared divider
  typedef struct packed {
    logic              start;
    logic [31:0]       dividend;
    logic [CNT_W-1:0]  divisor;
  } div_req_t;

endpackage

// ===== rtl/fcce_div.sv =====
// Restoring divider, one quotient bit per cycle.
module fcce_div (
  input  logic                     clk,
  input  logic                     rst,
  input  fcce_pkg::div_req_t       req,
  output logic                     done,
  output logic [31:0]              quotient,
  output logic [fcce_pkg::CNT_W-1:0] remainder
);
  import fcce_pkg::*;

  logic             busy;
  logic [4:0]       bit_cnt;
  logic [CNT_W:0]   trial;
  logic             fits;

  // Shift in the next dividend bit and test it against the divisor
  assign trial = {remainder, quotient[31]};
  assign fits  = trial >= {1'b0, req.divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      done    <= 1'b0;
      bit_cnt <= '0;
    end else begin
      // Pulse done on the last quotient bit
      done <= !req.start && busy && (bit_cnt == 5'd31);
      if (req.start) begin
        busy      <= 1'b1;
        bit_cnt   <= '0;
        quotient  <= req.dividend;
        remainder <= '0;
      end else if (busy) begin
        if (fits) begin
          remainder <= CNT_W'(trial - {1'b0, req.divisor});
        end else begin
          remainder <= trial[CNT_W-1:0];
        end
        quotient <= {quotient[30:0], fits};
        bit_cnt  <= bit_cnt + 5'd1;
        if (bit_cnt == 5'd31) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== rtl/fat_cluster_chain_engine_unit.sv =====
// Top level: cluster allocation table with allocate, free, map, read and write requests.
//
//  channel | handshake          | payload
//  --------+--------------------+-----------------------------------------------
//  in      | in_valid/in_stall  | req_type cluster prev block_index write_value
//  out     | out_valid/out_stall| found_cluster entry_value sector_number status
//          |                    | allocated_total
//  cfg     | cfg_wr_en          | cfg_index cfg_data
//
// One request at a time. Allocate scans entries in order through the single table
// read port. Map divides the block number by sectors per cluster, then follows the
// chain link by link; for chains longer than the table it measures the loop length
// and divides again to skip whole turns.
// After reset a clearing pass writes all 4096 entries, with in_stall high.
// A finished result waits in the output register; in_stall is low whenever the
// sequencer is idle.
module fat_cluster_chain_engine_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  req_type,
  input  logic [11:0] cluster,
  input  logic [11:0] prev,
  input  logic [31:0] block_index,
  input  logic [31:0] write_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] found_cluster,
  output logic [31:0] entry_value,
  output logic [31:0] sector_number,
  output logic [1:0]  status,
  output logic [31:0] allocated_total,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import fcce_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_A_SCAN, S_A_LINK, S_A_MARK, S_F_PREV, S_F_CLR,
    S_R_ISSUE, S_R_WAIT, S_W_ENTRY, S_M_DIV, S_W_ISSUE, S_W_WAIT, S_M_REM,
    S_M_MUL, S_M_SUM, S_DONE
  } state_t;

  typedef enum logic [1:0] {P_FIRST, P_MEASURE, P_REST} phase_t;

  state_t state;
  phase_t phase;

  // Table memory
  logic [31:0]       table_mem [TABLE_DEPTH];
  logic [31:0]       rdata;
  logic [ADDR_W-1:0] rd_addr;
  logic              mem_we;
  logic [ADDR_W-1:0] wr_addr;
  logic [31:0]       wr_data;

  // Configuration
  logic [11:0] data_cluster_count;
  logic [7:0]  sectors_per_cluster;
  logic [31:0] first_data_sector;

  // Latched request
  logic [2:0]  req_q;
  logic [11:0] clus_q;
  logic [11:0] prev_q;
  logic [31:0] blk_q;
  logic [31:0] wval_q;

  // Working registers
  logic [ADDR_W-1:0] clr_addr;
  logic [CNT_W-1:0]  scan_addr;
  logic              pend;
  logic [ADDR_W-1:0] pend_addr;
  logic [31:0]       alloc_cnt;
  logic [11:0]       found_r;
  logic [31:0]       entry_r;
  logic [31:0]       sector_r;
  logic [1:0]        status_r;
  logic [31:0]       walk_c;
  logic [CNT_W-1:0]  step_cnt;
  logic              cyc;
  logic [ADDR_W-1:0] mark_c;
  logic [CNT_W-1:0]  cyc_len;
  logic [31:0]       n_q;
  logic [7:0]        blk_rem;
  logic [31:0]       prod;

  // Divider
  div_req_t          div_req;
  logic              div_done;
  logic [31:0]       div_q;
  logic [CNT_W-1:0]  div_r;

  // Derived values
  logic [ADDR_W-1:0] cnt_eff;
  logic [CNT_W-1:0]  last_valid;
  logic [CNT_W-1:0]  scan_limit;
  logic [7:0]        spc_eff;
  logic              scan_issue;
  logic              walk_in_range;
  logic              rd_is_link;
  logic [31:0]       prod_full;

  assign cnt_eff    = (data_cluster_count > MAX_COUNT) ? MAX_COUNT : data_cluster_count;
  assign last_valid = {1'b0, cnt_eff} + CNT_W'(1);
  assign scan_limit = {1'b0, cnt_eff} + CNT_W'(2);
  assign spc_eff    = (sectors_per_cluster == 8'd0) ? 8'd1 : sectors_per_cluster;
  assign scan_issue = scan_addr < scan_limit;
  assign walk_in_range = (walk_c >= FIRST_CLUSTER) &&
                         (walk_c <= {{(32-CNT_W){1'b0}}, last_valid});
  assign rd_is_link = (rdata >= FIRST_CLUSTER) && (rdata < END_THRESHOLD);
  assign prod_full  = (walk_c - FIRST_CLUSTER) * {24'd0, spc_eff};
  assign in_stall   = (state != S_IDLE);

  fcce_div u_div (
    .clk       (clk),
    .rst       (rst),
    .req       (div_req),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  // Pick the read address for the current step
  always_comb begin
    unique case (state)
      S_A_SCAN:  rd_addr = scan_addr[ADDR_W-1:0];
      S_R_ISSUE: rd_addr = clus_q;
      default:   rd_addr = walk_c[ADDR_W-1:0];
    endcase
  end

  // Pick the write for the current step; reads and writes never share a state
  always_comb begin
    mem_we  = 1'b0;
    wr_addr = clus_q;
    wr_data = '0;
    unique case (state)
      S_CLEAR: begin
        mem_we  = 1'b1;
        wr_addr = clr_addr;
      end
      S_A_LINK: begin
        mem_we  = (prev_q != '0);
        wr_addr = prev_q;
        wr_data = {20'd0, found_r};
      end
      S_A_MARK: begin
        mem_we  = 1'b1;
        wr_addr = found_r;
        wr_data = END_MARK;
      end
      S_F_PREV: begin
        mem_we  = (prev_q != '0);
        wr_addr = prev_q;
        wr_data = END_MARK;
      end
      S_F_CLR: begin
        mem_we  = 1'b1;
      end
      S_W_ENTRY: begin
        mem_we  = 1'b1;
        wr_data = wval_q;
      end
      default: begin
        mem_we  = 1'b0;
      end
    endcase
  end

  // Table storage
  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[wr_addr] <= wr_data;
    end
    rdata <= table_mem[rd_addr];
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      data_cluster_count  <= 12'd4094;
      sectors_per_cluster <= 8'd8;
      first_data_sector   <= 32'd0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_COUNT: data_cluster_count  <= cfg_data[11:0];
        CFG_SPC:   sectors_per_cluster <= cfg_data[7:0];
        CFG_FDS:   first_data_sector   <= cfg_data;
        default:   ;
      endcase
    end
  end

  // Request sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      phase         <= P_FIRST;
      clr_addr      <= '0;
      alloc_cnt     <= '0;
      out_valid     <= 1'b0;
      pend          <= 1'b0;
      div_req.start <= 1'b0;
    end else begin
      // Start a divide for the block number or for the loop turns
      div_req.start <= ((state == S_DISPATCH) && (req_q == REQ_MAP)) ||
                       ((state == S_W_WAIT) && (phase == P_MEASURE) && rd_is_link &&
                        (rdata == {{(32-ADDR_W){1'b0}}, mark_c}));
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        // Sweep the table to zero
        S_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == '1) begin
            state <= S_IDLE;
          end
        end
        // Take a transaction
        S_IDLE: begin
          if (in_valid) begin
            req_q    <= req_type;
            clus_q   <= cluster;
            prev_q   <= prev;
            blk_q    <= block_index;
            wval_q   <= write_value;
            found_r  <= '0;
            entry_r  <= '0;
            sector_r <= '0;
            status_r <= ST_OK;
            state    <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          unique case (req_q)
            REQ_ALLOC: begin
              scan_addr <= (prev_q == '0) ? CNT_W'(FIRST_CLUSTER)
                                          : {1'b0, prev_q} + CNT_W'(1);
              pend      <= 1'b0;
              state     <= S_A_SCAN;
            end
            REQ_FREE:  state <= S_F_PREV;
            REQ_MAP: begin
              div_req.dividend <= blk_q;
              div_req.divisor  <= {{(CNT_W-8){1'b0}}, spc_eff};
              state            <= S_M_DIV;
            end
            REQ_READ:  state <= S_R_ISSUE;
            REQ_WRITE: state <= S_W_ENTRY;
            default:   state <= S_DONE;
          endcase
        end
        // First-fit scan: issue one address a cycle, test the previous read
        S_A_SCAN: begin
          if (pend && rdata == '0) begin
            found_r <= pend_addr;
            state   <= S_A_LINK;
          end else if (scan_issue) begin
            pend      <= 1'b1;
            pend_addr <= scan_addr[ADDR_W-1:0];
            scan_addr <= scan_addr + CNT_W'(1);
          end else begin
            status_r <= ST_FULL;
            state    <= S_DONE;
          end
        end
        S_A_LINK: state <= S_A_MARK;
        S_A_MARK: begin
          alloc_cnt <= alloc_cnt + 32'd1;
          state     <= S_DONE;
        end
        S_F_PREV:  state <= S_F_CLR;
        S_F_CLR:   state <= S_DONE;
        S_W_ENTRY: state <= S_DONE;
        // Range-checked read
        S_R_ISSUE: begin
          if ({1'b0, clus_q} >= CNT_W'(FIRST_CLUSTER) && {1'b0, clus_q} <= last_valid) begin
            state <= S_R_WAIT;
          end else begin
            state <= S_DONE;
          end
        end
        S_R_WAIT: begin
          entry_r <= rdata;
          state   <= S_DONE;
        end
        // Block number over sectors per cluster gives the link count
        S_M_DIV: begin
          if (div_done) begin
            n_q      <= div_q;
            blk_rem  <= div_r[7:0];
            cyc      <= div_q > 32'(TABLE_DEPTH);
            step_cnt <= (div_q > 32'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : div_q[CNT_W-1:0];
            walk_c   <= {20'd0, clus_q};
            phase    <= P_FIRST;
            state    <= S_W_ISSUE;
          end
        end
        // Follow one link; past the table size the chain must loop
        S_W_ISSUE: begin
          if (phase != P_MEASURE && step_cnt == '0) begin
            if (phase == P_FIRST && cyc) begin
              mark_c  <= walk_c[ADDR_W-1:0];
              cyc_len <= '0;
              phase   <= P_MEASURE;
            end else begin
              state <= S_M_MUL;
            end
          end else if (!walk_in_range) begin
            status_r <= ST_BROKEN;
            state    <= S_DONE;
          end else begin
            state <= S_W_WAIT;
          end
        end
        S_W_WAIT: begin
          if (!rd_is_link) begin
            status_r <= ST_BROKEN;
            state    <= S_DONE;
          end else begin
            walk_c <= rdata;
            if (phase == P_MEASURE) begin
              cyc_len <= cyc_len + CNT_W'(1);
              if (rdata == {{(32-ADDR_W){1'b0}}, mark_c}) begin
                div_req.dividend <= n_q - 32'(TABLE_DEPTH);
                div_req.divisor  <= cyc_len + CNT_W'(1);
                state            <= S_M_REM;
              end else begin
                state <= S_W_ISSUE;
              end
            end else begin
              step_cnt <= step_cnt - CNT_W'(1);
              state    <= S_W_ISSUE;
            end
          end
        end
        // Remaining links after skipping whole turns of the loop
        S_M_REM: begin
          if (div_done) begin
            step_cnt <= div_r;
            phase    <= P_REST;
            state    <= S_W_ISSUE;
          end
        end
        S_M_MUL: begin
          prod  <= prod_full;
          state <= S_M_SUM;
        end
        S_M_SUM: begin
          sector_r <= first_data_sector + prod + {24'd0, blk_rem};
          state    <= S_DONE;
        end
        // Hand the result to the output register once it is free
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid       <= 1'b1;
            found_cluster   <= found_r;
            entry_value     <= entry_r;
            sector_number   <= sector_r;
            status          <= status_r;
            allocated_total <= alloc_cnt;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/fcce_checker.sv =====
// Port-level checks for the cluster chain engine, bound to the top level.
module fcce_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [11:0] found_cluster,
  input logic [1:0]  status
);
  import fcce_pkg::*;

  // The table is being cleared right after reset
  a_clear_after_reset: assert property (@(posedge clk) $past(rst) && !rst |-> in_stall)
    else $error("input taken during clearing pass");

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(found_cluster) && $stable(status))
    else $error("stalled result changed");

  // A full table gives no cluster
  a_full_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FULL |-> found_cluster == '0)
    else $error("full status with a cluster");

  // A given cluster is a data cluster and comes with ok status
  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && found_cluster != '0 |-> status == ST_OK && found_cluster >= 12'd2)
    else $error("bad allocated cluster");

endmodule

bind fat_cluster_chain_engine_unit fcce_checker u_fcce_checker (
  .clk           (clk),
  .rst           (rst),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .found_cluster (found_cluster),
  .status        (status)
);

// ===== verif/tb_fat_cluster_chain_engine_unit.sv =====
// Self-checking testbench for the cluster chain engine: directed and random traffic checked against a predictor.
module tb_fat_cluster_chain_engine_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import fcce_pkg::*;

  localparam logic [2:0] REQ_BAD_FIRST = 3'd5;
  localparam logic [2:0] REQ_BAD_LAST  = 3'd7;
  localparam int STALL_LIMIT = 200000;

  typedef struct packed {
    logic [2:0]  req;
    logic [11:0] clus;
    logic [11:0] prv;
    logic [31:0] blk;
    logic [31:0] wval;
  } fat_req_t;

  typedef struct packed {
    logic [11:0] found;
    logic [31:0] entry;
    logic [31:0] sector;
    logic [1:0]  status;
    logic [31:0] total;
  } fat_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0]  req_type = '0;
  logic [11:0] cluster = '0;
  logic [11:0] prev = '0;
  logic [31:0] block_index = '0;
  logic [31:0] write_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [11:0] found_cluster;
  logic [31:0] entry_value;
  logic [31:0] sector_number;
  logic [1:0]  status;
  logic [31:0] allocated_total;
  logic cfg_wr_en = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // Shadow of the engine state
  logic [31:0] fat_shadow [TABLE_DEPTH];
  logic [31:0] alloc_shadow;
  logic [31:0] count_shadow, spc_shadow, fds_shadow;
  int          visit_step [TABLE_DEPTH];

  fat_req_t pending_reqs[$];
  fat_rsp_t expected_rsps[$];
  int errors = 0;
  int req_seen = 0, rsp_seen = 0, full_seen = 0, broken_seen = 0, cycle_maps = 0;
  int gap_left = 0, stall_left = 0, idle_cycles = 0;
  bit burst_mode = 1'b0;

  fat_cluster_chain_engine_unit DUT (.*);

  always #2 clk = ~clk;

  function automatic logic [31:0] eff_count();
    return (count_shadow > TABLE_DEPTH - 2) ? TABLE_DEPTH - 2 : count_shadow;
  endfunction

  function automatic logic [31:0] eff_spc();
    return (spc_shadow == 0) ? 32'd1 : spc_shadow;
  endfunction

  function automatic logic [31:0] fat_read(logic [31:0] c);
    if (c < FIRST_CLUSTER || c > eff_count() + 1) return 32'd0;
    return fat_shadow[c];
  endfunction

  function automatic void fat_write(logic [31:0] c, logic [31:0] v);
    if (c < TABLE_DEPTH) fat_shadow[c] = v;
  endfunction

  function automatic bit is_link(logic [31:0] v);
    return v >= FIRST_CLUSTER && v < END_THRESHOLD;
  endfunction

  // Follow n links from start, skipping whole turns of a cycle; 0 if the chain ends
  function automatic bit walk_chain(logic [31:0] start, logic [31:0] n,
                                    output logic [31:0] endc);
    logic [31:0] c, nx, steps, rem;
    c = start;
    steps = 0;
    endc = 0;
    foreach (visit_step[i]) visit_step[i] = -1;
    while (steps < n) begin
      nx = fat_read(c);
      if (!is_link(nx)) return 1'b0;
      c = nx;
      steps++;
      if (c < TABLE_DEPTH) begin
        if (visit_step[c] >= 0) begin
          rem = (n - steps) % (steps - visit_step[c]);
          cycle_maps++;
          while (rem > 0) begin
            c = fat_read(c);
            rem--;
          end
          break;
        end
        visit_step[c] = steps;
      end
    end
    endc = c;
    return 1'b1;
  endfunction

  // Apply one request to the shadow state and return the response it should produce
  function automatic fat_rsp_t predict_response(fat_req_t r);
    fat_rsp_t rsp;
    logic [31:0] c, endc;
    rsp = '0;
    case (r.req)
      REQ_ALLOC: begin
        rsp.status = ST_FULL;
        for (c = (r.prv == 0) ? FIRST_CLUSTER : r.prv + 1; c < eff_count() + 2; c++) begin
          if (fat_read(c) == 0) begin
            if (r.prv != 0) fat_write(r.prv, c);
            fat_write(c, END_MARK);
            alloc_shadow++;
            rsp.found = c[11:0];
            rsp.status = ST_OK;
            break;
          end
        end
        if (rsp.status == ST_FULL) full_seen++;
      end
      REQ_FREE: begin
        if (r.prv != 0) fat_write(r.prv, END_MARK);
        fat_write(r.clus, 32'd0);
      end
      REQ_MAP: begin
        if (walk_chain(r.clus, r.blk / eff_spc(), endc))
          rsp.sector = fds_shadow + (endc - FIRST_CLUSTER) * eff_spc() + r.blk % eff_spc();
        else begin
          rsp.status = ST_BROKEN;
          broken_seen++;
        end
      end
      REQ_READ:  rsp.entry = fat_read(r.clus);
      REQ_WRITE: fat_write(r.clus, r.wval);
      default: ;
    endcase
    rsp.total = alloc_shadow;
    return rsp;
  endfunction

  function automatic int draw_wait();
    return burst_mode ? 0 : $urandom_range(0, 19);
  endfunction

  // Driver: present pending requests with random gaps
  always @(posedge clk) begin
    fat_req_t r;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        expected_rsps.push_back(predict_response({req_type, cluster, prev,
                                                  block_index, write_value}));
        req_seen++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          r = pending_reqs.pop_front();
          req_type <= r.req;
          cluster <= r.clus;
          prev <= r.prv;
          block_index <= r.blk;
          write_value <= r.wval;
          in_valid <= 1'b1;
          gap_left <= draw_wait();
          if ($urandom_range(0, 99) == 0) burst_mode = ~burst_mode;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(string name, logic [31:0] exp, logic [31:0] act);
    if (exp !== act) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, exp, act);
      errors++;
    end
  endfunction

  // Monitor: accept responses with random stalls and compare against the oldest expectation
  always @(posedge clk) begin
    fat_rsp_t e;
    int n;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        rsp_seen++;
        if (expected_rsps.size() == 0) begin
          $display("%0t: unexpected response, actual found %h entry %h sector %h status %h",
                   $realtime, found_cluster, entry_value, sector_number, status);
          errors++;
        end else begin
          e = expected_rsps.pop_front();
          check_field("found_cluster", e.found, found_cluster);
          check_field("entry_value", e.entry, entry_value);
          check_field("sector_number", e.sector, sector_number);
          check_field("status", e.status, status);
          check_field("allocated_total", e.total, allocated_total);
        end
        n = draw_wait();
        stall_left <= n;
        out_stall <= (n != 0);
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_stall <= (stall_left > 1);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: watchdog expired", $realtime);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || expected_rsps.size() != 0 || in_valid || in_stall)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_config(logic [31:0] count, logic [31:0] spc, logic [31:0] fds);
    logic [31:0] vals [3];
    vals = '{count, spc, fds};
    for (int i = 0; i < 3; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= i[1:0];
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
    count_shadow = count & 32'hFFF;
    spc_shadow = spc & 32'hFF;
    fds_shadow = fds;
    @(posedge clk);
  endtask

  function automatic void push_req(logic [2:0] rq, logic [11:0] c, logic [11:0] p,
                                   logic [31:0] b, logic [31:0] w);
    pending_reqs.push_back({rq, c, p, b, w});
  endfunction

  // Mostly clusters inside the managed range, sometimes any index
  function automatic logic [11:0] pick_cluster();
    logic [31:0] hi;
    hi = eff_count() + 2;
    if (hi > TABLE_DEPTH - 1) hi = TABLE_DEPTH - 1;
    if ($urandom_range(0, 9) == 0) return 12'($urandom_range(0, TABLE_DEPTH - 1));
    return 12'($urandom_range(2, hi));
  endfunction

  function automatic void push_random_req();
    int k;
    logic [31:0] s;
    k = $urandom_range(0, 99);
    s = eff_spc();
    if (k < 35)
      push_req(REQ_ALLOC, 12'($urandom), ($urandom_range(0, 1) == 0) ? 12'd0 : pick_cluster(),
               $urandom, $urandom);
    else if (k < 50)
      push_req(REQ_FREE, pick_cluster(),
               ($urandom_range(0, 2) == 0) ? 12'd0 : pick_cluster(), $urandom, $urandom);
    else if (k < 72)
      push_req(REQ_MAP, pick_cluster(), 12'($urandom),
               (k < 65) ? $urandom_range(0, s * 6) :
               (k < 70) ? $urandom_range(0, s * 200) : $urandom, $urandom);
    else if (k < 85)
      push_req(REQ_READ, pick_cluster(), 12'($urandom), $urandom, $urandom);
    else if (k < 97)
      push_req(REQ_WRITE, pick_cluster(), 12'($urandom), $urandom,
               (k < 92) ? 32'(pick_cluster()) : (k < 94) ? END_MARK : $urandom);
    else
      push_req(3'($urandom_range(REQ_BAD_FIRST, REQ_BAD_LAST)), 12'($urandom), 12'($urandom),
               $urandom, $urandom);
  endfunction

  task automatic run_phase(logic [31:0] count, logic [31:0] spc, logic [31:0] fds, int n);
    write_config(count, spc, fds);
    for (int i = 0; i < n; i++) push_random_req();
    wait_drained();
  endtask

  initial begin
    foreach (fat_shadow[i]) fat_shadow[i] = '0;
    alloc_shadow = '0;
    count_shadow = 32'd4094;
    spc_shadow = 32'd8;
    fds_shadow = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Let the table clearing pass finish
    wait_drained();

    // Directed: fill a tiny table, chain walks, broken and cyclic chains, odd indexes
    write_config(32'd6, 32'd4, 32'hFFFF_FF00);
    push_req(REQ_ALLOC, 12'd0, 12'd0, 32'd0, 32'd0);
    push_req(REQ_ALLOC, 12'd0, 12'd2, 32'd0, 32'd0);
    push_req(REQ_ALLOC, 12'd0, 12'd3, 32'd0, 32'd0);
    for (int i = 0; i < 4; i++) push_req(REQ_ALLOC, 12'd0, 12'd0, 32'd0, 32'd0);
    push_req(REQ_MAP, 12'd2, 12'd0, 32'd9, 32'd0);
    push_req(REQ_MAP, 12'd2, 12'd0, 32'd12, 32'd0);
    push_req(REQ_MAP, 12'd0, 12'd0, 32'd1, 32'd0);
    push_req(REQ_FREE, 12'd3, 12'd2, 32'd0, 32'd0);
    push_req(REQ_FREE, 12'd5, 12'd5, 32'd0, 32'd0);
    push_req(REQ_WRITE, 12'd6, 12'd0, 32'd0, 32'd7);
    push_req(REQ_WRITE, 12'd7, 12'd0, 32'd0, 32'd6);
    push_req(REQ_MAP, 12'd6, 12'd0, 32'hFFFF_FFFF, 32'd0);
    push_req(REQ_WRITE, 12'hFFF, 12'hFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_req(REQ_READ, 12'hFFF, 12'd0, 32'd0, 32'd0);
    push_req(REQ_READ, 12'd0, 12'd0, 32'd0, 32'd0);
    push_req(REQ_READ, 12'd7, 12'd0, 32'd0, 32'd0);
    push_req(REQ_READ, 12'd8, 12'd0, 32'd0, 32'd0);
    push_req(REQ_ALLOC, 12'd0, 12'hFFF, 32'd0, 32'd0);
    push_req(REQ_WRITE, 12'd4, 12'd0, 32'd0, END_THRESHOLD);
    push_req(REQ_MAP, 12'd2, 12'd0, 32'd8, 32'd0);
    push_req(REQ_BAD_FIRST, 12'hFFF, 12'hFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_req(REQ_BAD_LAST, 12'd0, 12'd0, 32'd0, 32'd0);
    wait_drained();

    // Random phases across register settings, each ending with the sender held until drained
    run_phase(32'd4094, 32'd8, 32'd0, 200);
    run_phase(32'd0, 32'd0, 32'd12345, 150);
    run_phase(32'd60, 32'd1, 32'd0, 220);
    run_phase(32'd4095, 32'd255, 32'hFFFF_FFFF, 200);
    run_phase(32'd30, 32'd128, $urandom, 220);
    run_phase(32'd200, 32'd3, $urandom, 200);

    $display("Covered %0d requests and %0d responses over 7 register settings;", req_seen,
             rsp_seen);
    $display("  %0d full allocations, %0d broken chains, %0d cycle skips in chain walks.",
             full_seen, broken_seen, cycle_maps);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/fcce_pkg.sv
rtl/fcce_div.sv
rtl/fat_cluster_chain_engine_unit.sv
rtl/fcce_checker.sv
verif/tb_fat_cluster_chain_engine_unit.sv
